@@ rtl/core/rgbpc_pkg.sv @@
package rgbpc_pkg;

    localparam int PIX_W  = 8;
    localparam int FRAC_W = 40;
    localparam int ACC_W  = 64;
    localparam int COEF_W = 46;
    localparam int TERM_W = 32;
    localparam int PROD_W = 53;
    localparam int NX     = 9;
    localparam int NG     = 5;

    typedef logic [COEF_W-1:0] coef_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
        logic             last_pixel;
    } pix_in_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_out;
        logic [PIX_W-1:0] green_out;
        logic [PIX_W-1:0] blue_out;
        logic             last_out;
    } pix_out_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
    } pwr_en_t;

    typedef struct packed {
        logic                     last;
        logic [PIX_W-1:0]         r;
        logic [PIX_W-1:0]         g;
        logic [PIX_W-1:0]         b;
        logic [2*PIX_W-1:0]       r2;
        logic [2*PIX_W-1:0]       g2;
        logic [2*PIX_W-1:0]       b2;
        logic [2*PIX_W-1:0]       rg;
        logic [2*PIX_W-1:0]       bg;
        logic [3*PIX_W-1:0]       r3;
        logic [3*PIX_W-1:0]       g3;
        logic [3*PIX_W-1:0]       b3;
        logic [3*PIX_W-1:0]       r2g;
        logic [3*PIX_W-1:0]       b2g;
        logic [4*PIX_W-1:0]       r4;
        logic [4*PIX_W-1:0]       g4;
        logic [4*PIX_W-1:0]       b4;
        logic [4*PIX_W-1:0]       r3g;
        logic [4*PIX_W-1:0]       b3g;
    } terms_t;

    // Q40 magnitudes, round half up; terms 1, x, g, x2, xg, x3, x2g, x4, x3g
    localparam coef_t RED_MAG [NX] = '{
        COEF_W'(((64'd1837 << FRAC_W) + 64'd50) / 64'd100),
        COEF_W'(((64'd105 << FRAC_W) + 64'd50) / 64'd100),
        COEF_W'(((64'd276 << FRAC_W) + 64'd5000) / 64'd10000),
        COEF_W'(((64'd3275 << FRAC_W) + 64'd50000) / 64'd100000),
        COEF_W'(((64'd1056 << FRAC_W) + 64'd500000) / 64'd1000000),
        COEF_W'(((64'd152 << FRAC_W) + 64'd500000) / 64'd1000000),
        COEF_W'(((64'd2006 << FRAC_W) + 64'd500000000) / 64'd1000000000),
        COEF_W'(((64'd2091 << FRAC_W) + 64'd5000000000) / 64'd10000000000),
        COEF_W'(((64'd9682 << FRAC_W) + 64'd500000000000) / 64'd1000000000000)
    };
    localparam logic [NX-1:0] RED_NEG = 9'b000110110;

    // terms 1, g, g2, g3, g4
    localparam coef_t GRN_MAG [NG] = '{
        COEF_W'(((64'd687 << FRAC_W) + 64'd50) / 64'd100),
        COEF_W'(((64'd1453 << FRAC_W) + 64'd5000) / 64'd10000),
        COEF_W'(((64'd2435 << FRAC_W) + 64'd50000) / 64'd100000),
        COEF_W'(((64'd1355 << FRAC_W) + 64'd5000000) / 64'd10000000),
        COEF_W'(((64'd2267 << FRAC_W) + 64'd5000000000) / 64'd10000000000)
    };
    localparam logic [NG-1:0] GRN_NEG = 5'b01010;

    localparam coef_t BLU_MAG [NX] = '{
        COEF_W'(((64'd133 << FRAC_W) + 64'd5) / 64'd10),
        COEF_W'(((64'd4149 << FRAC_W) + 64'd5000) / 64'd10000),
        COEF_W'(((64'd8369 << FRAC_W) + 64'd50000) / 64'd100000),
        COEF_W'(((64'd1699 << FRAC_W) + 64'd50000) / 64'd100000),
        COEF_W'(((64'd1413 << FRAC_W) + 64'd500000) / 64'd1000000),
        COEF_W'(((64'd9235 << FRAC_W) + 64'd50000000) / 64'd100000000),
        COEF_W'(((64'd1239 << FRAC_W) + 64'd50000000) / 64'd100000000),
        COEF_W'(((64'd1334 << FRAC_W) + 64'd5000000000) / 64'd10000000000),
        COEF_W'(((64'd2221 << FRAC_W) + 64'd50000000000) / 64'd100000000000)
    };
    localparam logic [NX-1:0] BLU_NEG = 9'b100110100;

endpackage

@@ rtl/core/rgb_polynomial_tone_curve.sv @@
//  channel  handshake             payload     fields
//  src      src_valid/src_stall   pix_in_t    red_in green_in blue_in last_pixel
//  dst      dst_valid/dst_stall   pix_out_t   red_out green_out blue_out last_out
//
//  One pixel per clock while dst_stall is low; 3 power stages, coefficient
//  products, partial sums, final sum and clamp into the output register.
//  Reset clears only the stage valid bits.
//  Each stage holds only while it is full and the stage after it holds,
//  so a dst stall is absorbed by any bubbles before src_stall rises.
module rgb_polynomial_tone_curve import rgbpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     src_valid,
    output logic     src_stall,
    input  pix_in_t  src_word,
    output logic     dst_valid,
    input  logic     dst_stall,
    output pix_out_t dst_word
);

    localparam int STAGES = 6;
    localparam int ST_PROD = 3;
    localparam int ST_PART = 4;
    localparam int ST_OUT  = 5;

    function automatic logic signed [ACC_W-1:0] signed_term(
        input logic [PROD_W-1:0] p,
        input logic              neg
    );
        logic signed [ACC_W-1:0] ext;
        ext = signed'(ACC_W'(p));
        return neg ? -ext : ext;
    endfunction

    function automatic logic [PIX_W-1:0] finish(input logic signed [ACC_W-1:0] acc);
        logic [ACC_W-FRAC_W-1:0] whole;
        whole = acc[ACC_W-1:FRAC_W];
        if (acc[ACC_W-1])
            return '0;
        else if (whole > (ACC_W-FRAC_W)'(8'hFF))
            return '1;
        else
            return whole[PIX_W-1:0];
    endfunction

    logic [STAGES-1:0] valid_reg, valid_next;
    logic [STAGES-1:0] advance;

    pwr_en_t pwr_en;
    terms_t  terms;

    logic [TERM_W-1:0] red_term [1:NX-1];
    logic [TERM_W-1:0] grn_term [1:NG-1];
    logic [TERM_W-1:0] blu_term [1:NX-1];

    logic [PROD_W-1:0] red_prod_reg [1:NX-1];
    logic [PROD_W-1:0] grn_prod_reg [1:NG-1];
    logic [PROD_W-1:0] blu_prod_reg [1:NX-1];
    logic              prod_last_reg;

    logic signed [ACC_W-1:0] red_pv [0:NX-1];
    logic signed [ACC_W-1:0] grn_pv [0:NG-1];
    logic signed [ACC_W-1:0] blu_pv [0:NX-1];

    logic signed [ACC_W-1:0] red_part_reg [3], red_part_next [3];
    logic signed [ACC_W-1:0] grn_part_reg [2], grn_part_next [2];
    logic signed [ACC_W-1:0] blu_part_reg [3], blu_part_next [3];
    logic                    part_last_reg;

    logic signed [ACC_W-1:0] red_acc, grn_acc, blu_acc;
    pix_out_t                out_reg, out_next;

    // stage flow control
    always_comb
    begin
        advance[STAGES-1] = !valid_reg[STAGES-1] || !dst_stall;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            advance[k] = !valid_reg[k] || advance[k+1];
        end
        valid_next[0] = advance[0] ? src_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = advance[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
            valid_reg <= valid_next;
    end

    assign src_stall = !advance[0];
    assign pwr_en.s1 = advance[0];
    assign pwr_en.s2 = advance[1];
    assign pwr_en.s3 = advance[2];

    rgbpc_powers u_powers
    (
        .clk   (clk),
        .en    (pwr_en),
        .word  (src_word),
        .terms (terms)
    );

    always_comb
    begin
        red_term[1] = TERM_W'(terms.r);
        red_term[2] = TERM_W'(terms.g);
        red_term[3] = TERM_W'(terms.r2);
        red_term[4] = TERM_W'(terms.rg);
        red_term[5] = TERM_W'(terms.r3);
        red_term[6] = TERM_W'(terms.r2g);
        red_term[7] = TERM_W'(terms.r4);
        red_term[8] = TERM_W'(terms.r3g);

        grn_term[1] = TERM_W'(terms.g);
        grn_term[2] = TERM_W'(terms.g2);
        grn_term[3] = TERM_W'(terms.g3);
        grn_term[4] = TERM_W'(terms.g4);

        blu_term[1] = TERM_W'(terms.b);
        blu_term[2] = TERM_W'(terms.g);
        blu_term[3] = TERM_W'(terms.b2);
        blu_term[4] = TERM_W'(terms.bg);
        blu_term[5] = TERM_W'(terms.b3);
        blu_term[6] = TERM_W'(terms.b2g);
        blu_term[7] = TERM_W'(terms.b4);
        blu_term[8] = TERM_W'(terms.b3g);
    end

    // coefficient products, magnitudes only
    always_ff @(posedge clk)
    begin
        if (advance[ST_PROD])
        begin
            prod_last_reg <= terms.last;
            for (int i = 1; i < NX; i++)
            begin
                red_prod_reg[i] <= PROD_W'(RED_MAG[i]) * PROD_W'(red_term[i]);
                blu_prod_reg[i] <= PROD_W'(BLU_MAG[i]) * PROD_W'(blu_term[i]);
            end
            for (int i = 1; i < NG; i++)
            begin
                grn_prod_reg[i] <= PROD_W'(GRN_MAG[i]) * PROD_W'(grn_term[i]);
            end
        end
    end

    // signs applied, partial sums of up to three terms
    always_comb
    begin
        red_pv[0] = signed_term(PROD_W'(RED_MAG[0]), RED_NEG[0]);
        blu_pv[0] = signed_term(PROD_W'(BLU_MAG[0]), BLU_NEG[0]);
        grn_pv[0] = signed_term(PROD_W'(GRN_MAG[0]), GRN_NEG[0]);
        for (int i = 1; i < NX; i++)
        begin
            red_pv[i] = signed_term(red_prod_reg[i], RED_NEG[i]);
            blu_pv[i] = signed_term(blu_prod_reg[i], BLU_NEG[i]);
        end
        for (int i = 1; i < NG; i++)
        begin
            grn_pv[i] = signed_term(grn_prod_reg[i], GRN_NEG[i]);
        end
        for (int p = 0; p < 3; p++)
        begin
            red_part_next[p] = red_pv[3*p] + red_pv[3*p+1] + red_pv[3*p+2];
            blu_part_next[p] = blu_pv[3*p] + blu_pv[3*p+1] + blu_pv[3*p+2];
        end
        grn_part_next[0] = grn_pv[0] + grn_pv[1] + grn_pv[2];
        grn_part_next[1] = grn_pv[3] + grn_pv[4];
    end

    always_ff @(posedge clk)
    begin
        if (advance[ST_PART])
        begin
            part_last_reg <= prod_last_reg;
            red_part_reg  <= red_part_next;
            grn_part_reg  <= grn_part_next;
            blu_part_reg  <= blu_part_next;
        end
    end

    // final sum, truncate, clamp
    always_comb
    begin
        red_acc            = red_part_reg[0] + red_part_reg[1] + red_part_reg[2];
        grn_acc            = grn_part_reg[0] + grn_part_reg[1];
        blu_acc            = blu_part_reg[0] + blu_part_reg[1] + blu_part_reg[2];
        out_next.red_out   = finish(red_acc);
        out_next.green_out = finish(grn_acc);
        out_next.blue_out  = finish(blu_acc);
        out_next.last_out  = part_last_reg;
    end

    always_ff @(posedge clk)
    begin
        if (advance[ST_OUT])
            out_reg <= out_next;
    end

    assign dst_valid = valid_reg[ST_OUT];
    assign dst_word  = out_reg;

endmodule

@@ rtl/core/rgbpc_powers.sv @@
module rgbpc_powers import rgbpc_pkg::*;
(
    input  logic    clk,
    input  pwr_en_t en,
    input  pix_in_t word,
    output terms_t  terms
);

    localparam int W1 = PIX_W;
    localparam int W2 = 2 * PIX_W;
    localparam int W3 = 3 * PIX_W;
    localparam int W4 = 4 * PIX_W;

    logic          s1_last_reg;
    logic [W1-1:0] s1_r_reg, s1_g_reg, s1_b_reg;
    logic [W2-1:0] s1_r2_reg, s1_g2_reg, s1_b2_reg, s1_rg_reg, s1_bg_reg;

    logic          s2_last_reg;
    logic [W1-1:0] s2_r_reg, s2_g_reg, s2_b_reg;
    logic [W2-1:0] s2_r2_reg, s2_g2_reg, s2_b2_reg, s2_rg_reg, s2_bg_reg;
    logic [W3-1:0] s2_r3_reg, s2_g3_reg, s2_b3_reg, s2_r2g_reg, s2_b2g_reg;

    terms_t        terms_reg;

    // squares and first cross terms
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            s1_last_reg <= word.last_pixel;
            s1_r_reg    <= word.red_in;
            s1_g_reg    <= word.green_in;
            s1_b_reg    <= word.blue_in;
            s1_r2_reg   <= W2'(word.red_in) * W2'(word.red_in);
            s1_g2_reg   <= W2'(word.green_in) * W2'(word.green_in);
            s1_b2_reg   <= W2'(word.blue_in) * W2'(word.blue_in);
            s1_rg_reg   <= W2'(word.red_in) * W2'(word.green_in);
            s1_bg_reg   <= W2'(word.blue_in) * W2'(word.green_in);
        end
    end

    // cubes and cubic cross terms
    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            s2_last_reg <= s1_last_reg;
            s2_r_reg    <= s1_r_reg;
            s2_g_reg    <= s1_g_reg;
            s2_b_reg    <= s1_b_reg;
            s2_r2_reg   <= s1_r2_reg;
            s2_g2_reg   <= s1_g2_reg;
            s2_b2_reg   <= s1_b2_reg;
            s2_rg_reg   <= s1_rg_reg;
            s2_bg_reg   <= s1_bg_reg;
            s2_r3_reg   <= W3'(s1_r2_reg) * W3'(s1_r_reg);
            s2_g3_reg   <= W3'(s1_g2_reg) * W3'(s1_g_reg);
            s2_b3_reg   <= W3'(s1_b2_reg) * W3'(s1_b_reg);
            s2_r2g_reg  <= W3'(s1_r2_reg) * W3'(s1_g_reg);
            s2_b2g_reg  <= W3'(s1_b2_reg) * W3'(s1_g_reg);
        end
    end

    // fourth powers and quartic cross terms
    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            terms_reg.last <= s2_last_reg;
            terms_reg.r    <= s2_r_reg;
            terms_reg.g    <= s2_g_reg;
            terms_reg.b    <= s2_b_reg;
            terms_reg.r2   <= s2_r2_reg;
            terms_reg.g2   <= s2_g2_reg;
            terms_reg.b2   <= s2_b2_reg;
            terms_reg.rg   <= s2_rg_reg;
            terms_reg.bg   <= s2_bg_reg;
            terms_reg.r3   <= s2_r3_reg;
            terms_reg.g3   <= s2_g3_reg;
            terms_reg.b3   <= s2_b3_reg;
            terms_reg.r2g  <= s2_r2g_reg;
            terms_reg.b2g  <= s2_b2g_reg;
            terms_reg.r4   <= W4'(s2_r3_reg) * W4'(s2_r_reg);
            terms_reg.g4   <= W4'(s2_g3_reg) * W4'(s2_g_reg);
            terms_reg.b4   <= W4'(s2_b3_reg) * W4'(s2_b_reg);
            terms_reg.r3g  <= W4'(s2_r3_reg) * W4'(s2_g_reg);
            terms_reg.b3g  <= W4'(s2_b3_reg) * W4'(s2_g_reg);
        end
    end

    assign terms = terms_reg;

endmodule

@@ verif/rgb_polynomial_tone_curve_test.sv @@
module rgb_polynomial_tone_curve_test import rgbpc_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int  IDLE_PCT      = 29;
    localparam int  RANDOM_PIXELS = 2000;
    localparam int  HOLD_AT       = 700;
    localparam int  HOLD_CYCLES   = 400;
    localparam int  CALM_FROM     = 2000;
    localparam int  CALM_TO       = 2600;
    localparam int  DRAIN_CYCLES  = 20;
    localparam int  CYCLE_LIMIT   = 200000;
    localparam int  SHOW_LIMIT    = 10;
    localparam int  RED_SET       = 0;
    localparam int  BLUE_SET      = 1;

    logic     clk = 1'b0;
    logic     rst_n = 1'b0;
    logic     src_valid = 1'b0;
    logic     src_stall;
    pix_in_t  src_word = '0;
    logic     dst_valid;
    logic     dst_stall = 1'b0;
    pix_out_t dst_word;

    pix_in_t  pending_pixels[$];
    pix_out_t expected_tones[$];

    // Q40 coefficient sets: [set][1, x, g, x2, xg, x3, x2g, x4, x3g]
    longint   xg_coef[2][9];
    longint   green_coef[5];

    int       cycle_count = 0;
    int       pixels_sent = 0;
    int       hold_left = 0;
    bit       hold_done = 1'b0;
    int       error_count = 0;
    logic     calm;

    rgb_polynomial_tone_curve u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_stall (src_stall),
        .src_word  (src_word),
        .dst_valid (dst_valid),
        .dst_stall (dst_stall),
        .dst_word  (dst_word)
    );

    always #4 clk = ~clk;

    assign calm = (cycle_count >= CALM_FROM) && (cycle_count < CALM_TO);

    function automatic longint q40(longint num, longint den);
        return ((num << 40) + den / 2) / den;
    endfunction

    function automatic logic [7:0] clamp_byte(longint acc);
        longint v;
        if (acc < 0)
            return 8'd0;
        v = acc >>> 40;
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    function automatic longint curve_xg(int set, longint x, longint g);
        longint x2;
        longint x3;
        x2 = x * x;
        x3 = x2 * x;
        return xg_coef[set][0] + xg_coef[set][1] * x + xg_coef[set][2] * g
             + xg_coef[set][3] * x2 + xg_coef[set][4] * (x * g)
             + xg_coef[set][5] * x3 + xg_coef[set][6] * (x2 * g)
             + xg_coef[set][7] * (x3 * x) + xg_coef[set][8] * (x3 * g);
    endfunction

    function automatic pix_out_t tone_of(pix_in_t p);
        longint   r;
        longint   g;
        longint   b;
        longint   g2;
        longint   gsum;
        pix_out_t t;
        r = p.red_in;
        g = p.green_in;
        b = p.blue_in;
        g2 = g * g;
        gsum = green_coef[0] + green_coef[1] * g + green_coef[2] * g2
             + green_coef[3] * g2 * g + green_coef[4] * g2 * g2;
        t.red_out   = clamp_byte(curve_xg(RED_SET, r, g));
        t.green_out = clamp_byte(gsum);
        t.blue_out  = clamp_byte(curve_xg(BLUE_SET, b, g));
        t.last_out  = p.last_pixel;
        return t;
    endfunction

    task automatic queue_pixel(int r, int g, int b, bit last);
        pix_in_t p;
        p.red_in     = r[7:0];
        p.green_in   = g[7:0];
        p.blue_in    = b[7:0];
        p.last_pixel = last;
        pending_pixels.push_back(p);
    endtask

    task automatic note_error(string field, int want, int got);
        if (error_count < SHOW_LIMIT)
            $display("mismatch %s: expected %0d, got %0d", field, want, got);
        error_count++;
    endtask

    function automatic int rand_channel();
        if ($urandom_range(9) == 0)
            return $urandom_range(1) * 255;
        return $urandom_range(255);
    endfunction

    // sender
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_word  <= '0;
        end
        else
        begin
            if (src_valid && !src_stall)
            begin
                expected_tones.push_back(tone_of(src_word));
                pixels_sent <= pixels_sent + 1;
            end
            if (!src_valid || !src_stall)
            begin
                if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT))
                begin
                    src_word  <= pending_pixels.pop_front();
                    src_valid <= 1'b1;
                end
                else
                begin
                    src_valid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        if (!rst_n)
        begin
            dst_stall <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else
        begin
            if (dst_valid && !dst_stall)
            begin
                if (expected_tones.size() == 0)
                begin
                    note_error("unexpected word", 0, dst_word);
                end
                else
                begin
                    want = expected_tones.pop_front();
                    if (dst_word.red_out !== want.red_out)
                        note_error("red_out", want.red_out, dst_word.red_out);
                    if (dst_word.green_out !== want.green_out)
                        note_error("green_out", want.green_out, dst_word.green_out);
                    if (dst_word.blue_out !== want.blue_out)
                        note_error("blue_out", want.blue_out, dst_word.blue_out);
                    if (dst_word.last_out !== want.last_out)
                        note_error("last_out", want.last_out, dst_word.last_out);
                end
            end
            // long hold-off so the pipeline fills and backs up into src
            if (!hold_done && pixels_sent >= HOLD_AT)
            begin
                hold_done <= 1'b1;
                hold_left <= HOLD_CYCLES;
                dst_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                dst_stall <= 1'b1;
            end
            else
            begin
                dst_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        xg_coef[RED_SET]  = '{q40(1837, 100), -q40(105, 100), -q40(276, 10000),
                              q40(3275, 100000), -q40(1056, 1000000),
                              -q40(152, 1000000), q40(2006, 1000000000),
                              q40(2091, 64'd10000000000),
                              q40(9682, 64'd1000000000000)};
        xg_coef[BLUE_SET] = '{q40(133, 10), q40(4149, 10000), -q40(8369, 100000),
                              q40(1699, 100000), -q40(1413, 1000000),
                              -q40(9235, 100000000), q40(1239, 100000000),
                              q40(1334, 64'd10000000000),
                              -q40(2221, 64'd100000000000)};
        green_coef = '{q40(687, 100), -q40(1453, 10000), q40(2435, 100000),
                       -q40(1355, 10000000), q40(2267, 64'd10000000000)};

        queue_pixel(0, 0, 0, 1'b0);
        queue_pixel(255, 255, 255, 1'b1);
        queue_pixel(255, 0, 0, 1'b0);
        queue_pixel(0, 255, 0, 1'b0);
        queue_pixel(0, 0, 255, 1'b1);
        queue_pixel(255, 255, 0, 1'b0);
        queue_pixel(0, 255, 255, 1'b0);
        queue_pixel(255, 0, 255, 1'b1);
        queue_pixel(1, 1, 1, 1'b0);
        queue_pixel(254, 254, 254, 1'b0);
        queue_pixel(127, 127, 127, 1'b1);
        queue_pixel(128, 128, 128, 1'b0);
        queue_pixel(170, 85, 170, 1'b0);
        queue_pixel(85, 170, 85, 1'b1);
        queue_pixel(64, 192, 32, 1'b0);
        queue_pixel(200, 100, 50, 1'b0);
        queue_pixel(16, 240, 8, 1'b1);
        queue_pixel(240, 16, 248, 1'b0);
        for (int i = 0; i < RANDOM_PIXELS; i++)
            queue_pixel(rand_channel(), rand_channel(), rand_channel(),
                        $urandom_range(7) == 0);

        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        while (pending_pixels.size() != 0 || src_valid || expected_tones.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
